FILE: design/http_request_framer_defines.svh
// Assertion macros for the request framer.
`ifndef HTTP_REQUEST_FRAMER_DEFINES_SVH
`define HTTP_REQUEST_FRAMER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define HRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define HRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hrf_pkg.sv
// Types, codes and constants of the request framer.
`default_nettype none

package hrf_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int BODY_LEN_W   = 32;
  localparam int NAME_LEN     = 14;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_URL     = 4'd1,
    PH_VERSION = 4'd2,
    PH_LINE_LF = 4'd3,
    PH_NAME    = 4'd4,
    PH_VALUE   = 4'd5,
    PH_DIGITS  = 4'd6,
    PH_END_LF  = 4'd7,
    PH_BODY    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CL_METHOD  = 3'd0,
    CL_URL     = 3'd1,
    CL_VERSION = 3'd2,
    CL_NAME    = 3'd3,
    CL_VALUE   = 3'd4,
    CL_BODY    = 3'd5,
    CL_SEP     = 3'd6,
    CL_DROP    = 3'd7
  } byte_class_t;

  // "Content-Length", one character per position
  function automatic logic [7:0] length_name_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: design/hrf_if.sv
// Stream interfaces for request bytes in and tagged bytes out.
`default_nettype none

interface hrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface hrf_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic [2:0]                    byte_class;
  logic                          request_done;
  logic                          request_aborted;
  logic [hrf_pkg::BODY_LEN_W-1:0] body_length;

  modport source (output valid, output out_byte, output byte_class, output request_done,
                  output request_aborted, output body_length, input ready);
  modport sink (input valid, input out_byte, input byte_class, input request_done,
                input request_aborted, input body_length, output ready);
endinterface

`default_nettype wire

FILE: design/http_request_framer.sv
// Request framer top level: parse state machine and output register.
// Each accepted byte's tagged result is held in the output register.
// Throughput: one byte per cycle unless the sink stalls; single parse pass per byte.
// Input ready is high when the output register is empty or being drained this cycle.
// Reset (rst_n low, synchronous) returns the parser to the method field and
// empties the output register.
`default_nettype none
`include "http_request_framer_defines.svh"

module http_request_framer #(
  parameter int LEN_BITS = hrf_pkg::LEN_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hrf_in_if.sink     in_ch,
  hrf_out_if.source  out_ch
);

  // Parse state
  hrf_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]            name_pos_r, name_pos_nxt;
  logic                  name_is_len_r, name_is_len_nxt;
  logic                  len_seen_r, len_seen_nxt;
  logic [LEN_BITS-1:0]   len_value_r, len_value_nxt;
  logic                  len_valid_r, len_valid_nxt;
  logic                  trail_space_r, trail_space_nxt;
  logic [LEN_BITS-1:0]   body_cnt_r, body_cnt_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r;
  hrf_pkg::byte_class_t          out_class_r;
  logic                          out_done_r;
  logic                          out_abort_r;
  logic [hrf_pkg::BODY_LEN_W-1:0] out_blen_r;

  // Per-byte results
  hrf_pkg::byte_class_t          cls;
  logic                          done;
  logic                          aborted;
  logic [hrf_pkg::BODY_LEN_W-1:0] blen;

  logic                          in_acc;
  logic [7:0]                    c;
  logic [7:0]                    digit_diff;
  logic [3:0]                    digit;
  logic                          is_digit;
  logic [LEN_BITS+3:0]           len_ext;
  logic [LEN_BITS+3:0]           len_times10;
  logic                          len_ovf;
  logic [LEN_BITS-1:0]           body_cnt_inc;
  logic [hrf_pkg::BODY_LEN_W+LEN_BITS-1:0] len_zext;

  // Byte is taken whenever the result slot is free or frees this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;

  // Decimal accumulate: value*10 + digit, overflow when any bit above LEN_BITS is set
  assign digit_diff  = c - hrf_pkg::CH_0;
  assign digit       = digit_diff[3:0];
  assign is_digit    = (c >= hrf_pkg::CH_0) && (c <= hrf_pkg::CH_9);
  assign len_ext     = {4'b0000, len_value_r};
  assign len_times10 = (len_ext << 3) + (len_ext << 1) + (LEN_BITS+4)'(digit);
  assign len_ovf     = |len_times10[LEN_BITS+3:LEN_BITS];

  assign body_cnt_inc = body_cnt_r + LEN_BITS'(1);

  // Low 32 bits of the length, zero-extended when LEN_BITS is narrower
  assign len_zext = {{hrf_pkg::BODY_LEN_W{1'b0}}, len_value_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= hrf_pkg::PH_METHOD;
      name_pos_r    <= '0;
      name_is_len_r <= 1'b0;
      len_seen_r    <= 1'b0;
      len_value_r   <= '0;
      len_valid_r   <= 1'b0;
      trail_space_r <= 1'b0;
      body_cnt_r    <= '0;
    end else if (in_acc) begin
      phase_r       <= phase_nxt;
      name_pos_r    <= name_pos_nxt;
      name_is_len_r <= name_is_len_nxt;
      len_seen_r    <= len_seen_nxt;
      len_value_r   <= len_value_nxt;
      len_valid_r   <= len_valid_nxt;
      trail_space_r <= trail_space_nxt;
      body_cnt_r    <= body_cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    name_pos_nxt    = name_pos_r;
    name_is_len_nxt = name_is_len_r;
    len_seen_nxt    = len_seen_r;
    len_value_nxt   = len_value_r;
    len_valid_nxt   = len_valid_r;
    trail_space_nxt = trail_space_r;
    body_cnt_nxt    = body_cnt_r;
    cls             = hrf_pkg::CL_SEP;
    done            = 1'b0;
    aborted         = 1'b0;
    blen            = '0;

    unique case (phase_r)
      // Request line: spaces split method/url, CR ends the version
      hrf_pkg::PH_METHOD: begin
        if (c == hrf_pkg::CH_SPACE) phase_nxt = hrf_pkg::PH_URL;
        else cls = hrf_pkg::CL_METHOD;
      end
      hrf_pkg::PH_URL: begin
        if (c == hrf_pkg::CH_SPACE) phase_nxt = hrf_pkg::PH_VERSION;
        else cls = hrf_pkg::CL_URL;
      end
      hrf_pkg::PH_VERSION: begin
        if (c == hrf_pkg::CH_CR) phase_nxt = hrf_pkg::PH_LINE_LF;
        else cls = hrf_pkg::CL_VERSION;
      end
      // LF after a line's CR; anything else throws the request away
      hrf_pkg::PH_LINE_LF: begin
        if (c == hrf_pkg::CH_LF) begin
          phase_nxt       = hrf_pkg::PH_NAME;
          name_pos_nxt    = '0;
          name_is_len_nxt = 1'b1;
        end else begin
          cls             = hrf_pkg::CL_DROP;
          aborted         = 1'b1;
          phase_nxt       = hrf_pkg::PH_METHOD;
          name_pos_nxt    = '0;
          name_is_len_nxt = 1'b0;
          len_seen_nxt    = 1'b0;
          len_value_nxt   = '0;
          len_valid_nxt   = 1'b0;
          trail_space_nxt = 1'b0;
          body_cnt_nxt    = '0;
        end
      end
      // Header name, matched against Content-Length as it streams past
      hrf_pkg::PH_NAME: begin
        if (c == hrf_pkg::CH_COLON) begin
          name_is_len_nxt = name_is_len_r && (name_pos_r == 4'(hrf_pkg::NAME_LEN));
          if (name_is_len_nxt) begin
            len_valid_nxt   = !len_seen_r;   // a repeat spoils the length
            len_seen_nxt    = 1'b1;
            len_value_nxt   = '0;
            trail_space_nxt = 1'b0;
          end
          phase_nxt = hrf_pkg::PH_VALUE;
        end else if (c == hrf_pkg::CH_CR) begin
          phase_nxt = hrf_pkg::PH_END_LF;
        end else begin
          cls = hrf_pkg::CL_NAME;
          if (name_is_len_r) begin
            if (name_pos_r < 4'(hrf_pkg::NAME_LEN) &&
                hrf_pkg::length_name_char(name_pos_r) == c) begin
              name_pos_nxt = name_pos_r + 4'd1;
            end else begin
              name_is_len_nxt = 1'b0;
            end
          end
        end
      end
      // Header value; for Content-Length, strict decimal with space trimming
      hrf_pkg::PH_VALUE, hrf_pkg::PH_DIGITS: begin
        if (c == hrf_pkg::CH_CR) begin
          if (name_is_len_r && phase_r == hrf_pkg::PH_VALUE) len_valid_nxt = 1'b0;
          phase_nxt = hrf_pkg::PH_LINE_LF;
        end else begin
          cls = hrf_pkg::CL_VALUE;
          if (name_is_len_r) begin
            if (c == hrf_pkg::CH_SPACE) begin
              if (phase_r == hrf_pkg::PH_DIGITS) trail_space_nxt = 1'b1;
            end else if (is_digit) begin
              if (phase_r == hrf_pkg::PH_DIGITS) begin
                if (trail_space_r || len_value_r == '0 || len_ovf) len_valid_nxt = 1'b0;
                else len_value_nxt = len_times10[LEN_BITS-1:0];
              end else begin
                len_value_nxt = LEN_BITS'(digit);
                phase_nxt     = hrf_pkg::PH_DIGITS;
              end
            end else begin
              len_valid_nxt = 1'b0;
            end
          end
        end
      end
      // LF of the blank line: finish now unless a body follows
      hrf_pkg::PH_END_LF: begin
        if (c == hrf_pkg::CH_LF) begin
          if (!len_seen_r || (len_valid_r && len_value_r == '0)) begin
            done            = 1'b1;
            phase_nxt       = hrf_pkg::PH_METHOD;
            name_pos_nxt    = '0;
            name_is_len_nxt = 1'b0;
            len_seen_nxt    = 1'b0;
            len_value_nxt   = '0;
            len_valid_nxt   = 1'b0;
            trail_space_nxt = 1'b0;
            body_cnt_nxt    = '0;
          end else begin
            body_cnt_nxt = '0;
            phase_nxt    = hrf_pkg::PH_BODY;
          end
        end else begin
          cls             = hrf_pkg::CL_DROP;
          aborted         = 1'b1;
          phase_nxt       = hrf_pkg::PH_METHOD;
          name_pos_nxt    = '0;
          name_is_len_nxt = 1'b0;
          len_seen_nxt    = 1'b0;
          len_value_nxt   = '0;
          len_valid_nxt   = 1'b0;
          trail_space_nxt = 1'b0;
          body_cnt_nxt    = '0;
        end
      end
      // Body: count bytes; with a bad length this never ends
      hrf_pkg::PH_BODY: begin
        cls          = hrf_pkg::CL_BODY;
        body_cnt_nxt = body_cnt_inc;
        if (len_valid_r && body_cnt_inc == len_value_r) begin
          done            = 1'b1;
          blen            = len_zext[hrf_pkg::BODY_LEN_W-1:0];
          phase_nxt       = hrf_pkg::PH_METHOD;
          name_pos_nxt    = '0;
          name_is_len_nxt = 1'b0;
          len_seen_nxt    = 1'b0;
          len_value_nxt   = '0;
          len_valid_nxt   = 1'b0;
          trail_space_nxt = 1'b0;
          body_cnt_nxt    = '0;
        end
      end
      // Unused phase codes recover to a fresh request
      default: begin
        cls             = hrf_pkg::CL_DROP;
        phase_nxt       = hrf_pkg::PH_METHOD;
        name_pos_nxt    = '0;
        name_is_len_nxt = 1'b0;
        len_seen_nxt    = 1'b0;
        len_value_nxt   = '0;
        len_valid_nxt   = 1'b0;
        trail_space_nxt = 1'b0;
        body_cnt_nxt    = '0;
      end
    endcase
  end

  // Result register: holds a transaction until the sink takes it
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_r  <= c;
      out_class_r <= cls;
      out_done_r  <= done;
      out_abort_r <= aborted;
      out_blen_r  <= blen;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_byte        = out_byte_r;
  assign out_ch.byte_class      = out_class_r;
  assign out_ch.request_done    = out_done_r;
  assign out_ch.request_aborted = out_abort_r;
  assign out_ch.body_length     = out_blen_r;

  `HRF_ASSERT_NOW(a_done_abort_excl, out_valid_r, !(out_done_r && out_abort_r), "done and aborted together")
  `HRF_ASSERT_NOW(a_abort_is_drop, out_valid_r && out_abort_r, out_class_r == hrf_pkg::CL_DROP, "abort not tagged dropped")
  `HRF_ASSERT_NOW(a_len_only_body, out_valid_r && out_blen_r != '0, out_done_r && out_class_r == hrf_pkg::CL_BODY, "length outside body end")
  `HRF_ASSERT_NOW(a_body_needs_len, phase_r == hrf_pkg::PH_BODY, len_seen_r, "body without Content-Length")
  `HRF_ASSERT_NEXT(a_accept_shows, in_acc, out_valid_r, "accepted byte gave no result")

endmodule

`default_nettype wire

FILE: bench/hrf_checker.sv
// Request framer checker: tags each accepted request byte and compares the tagged output.
`timescale 1ns / 100ps

module hrf_checker import hrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hrf_in_if    in_mon,
  hrf_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   requests_done,
  output int   requests_aborted,
  output int   bytes_checked
);

  localparam logic [8*NAME_LEN-1:0] LENGTH_HEADER = "Content-Length";
  localparam logic [63:0]           LEN_MASK      = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        done;
    logic        aborted;
    logic [31:0] blen;
  } framed_byte_t;

  framed_byte_t predicted_tags[$];

  // parser copy
  phase_t      ph;
  logic [3:0]  match_pos;
  logic        hdr_is_length;
  logic        length_seen;
  logic        length_ok;
  logic        trail_space;
  logic [31:0] length_value;
  logic [31:0] body_taken;

  function automatic void clear_parse();
    ph            = PH_METHOD;
    match_pos     = '0;
    hdr_is_length = 1'b0;
    length_seen   = 1'b0;
    length_ok     = 1'b0;
    trail_space   = 1'b0;
    length_value  = '0;
    body_taken    = '0;
  endfunction

  function automatic framed_byte_t frame_byte(input logic [7:0] c);
    framed_byte_t r;
    logic [63:0]  d;
    r.data    = c;
    r.cls     = CL_SEP;
    r.done    = 1'b0;
    r.aborted = 1'b0;
    r.blen    = '0;
    case (ph)
      PH_METHOD: begin
        if (c == CH_SPACE) ph = PH_URL;
        else r.cls = CL_METHOD;
      end
      PH_URL: begin
        if (c == CH_SPACE) ph = PH_VERSION;
        else r.cls = CL_URL;
      end
      PH_VERSION: begin
        if (c == CH_CR) ph = PH_LINE_LF;
        else r.cls = CL_VERSION;
      end
      PH_LINE_LF: begin
        if (c == CH_LF) begin
          ph            = PH_NAME;
          match_pos     = '0;
          hdr_is_length = 1'b1;
        end else begin
          r.cls     = CL_DROP;
          r.aborted = 1'b1;
          clear_parse();
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          hdr_is_length = hdr_is_length && (match_pos == NAME_LEN);
          if (hdr_is_length) begin
            length_ok    = !length_seen;
            length_seen  = 1'b1;
            length_value = '0;
            trail_space  = 1'b0;
          end
          ph = PH_VALUE;
        end else if (c == CH_CR) begin
          ph = PH_END_LF;
        end else begin
          r.cls = CL_NAME;
          if (hdr_is_length) begin
            if (match_pos < NAME_LEN &&
                LENGTH_HEADER[8*(NAME_LEN-1-match_pos) +: 8] == c)
              match_pos = match_pos + 4'd1;
            else
              hdr_is_length = 1'b0;
          end
        end
      end
      PH_VALUE, PH_DIGITS: begin
        if (c == CH_CR) begin
          if (hdr_is_length && ph == PH_VALUE) length_ok = 1'b0;
          ph = PH_LINE_LF;
        end else begin
          r.cls = CL_VALUE;
          if (hdr_is_length) begin
            if (c == CH_SPACE) begin
              if (ph == PH_DIGITS) trail_space = 1'b1;
            end else if (c >= CH_0 && c <= CH_9) begin
              d = 64'(c - CH_0);
              if (ph == PH_DIGITS) begin
                if (trail_space || length_value == 0 ||
                    64'(length_value) > (LEN_MASK - d) / 64'd10)
                  length_ok = 1'b0;
                else
                  length_value = 32'(64'(length_value) * 64'd10 + d);
              end else begin
                length_value = 32'(d);
                ph           = PH_DIGITS;
              end
            end else begin
              length_ok = 1'b0;
            end
          end
        end
      end
      PH_END_LF: begin
        if (c == CH_LF) begin
          if (!length_seen || (length_ok && length_value == 0)) begin
            r.done = 1'b1;
            clear_parse();
          end else begin
            body_taken = '0;
            ph         = PH_BODY;
          end
        end else begin
          r.cls     = CL_DROP;
          r.aborted = 1'b1;
          clear_parse();
        end
      end
      PH_BODY: begin
        r.cls      = CL_BODY;
        body_taken = body_taken + 32'd1;
        if (length_ok && body_taken == length_value) begin
          r.done = 1'b1;
          r.blen = length_value;
          clear_parse();
        end
      end
      default: begin
        clear_parse();
        r.cls = CL_DROP;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] byte %0d %s: expected %0h, got %0h",
                 $time, bytes_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin : sample_edge
    framed_byte_t want;
    if (!rst_n) begin
      clear_parse();
      predicted_tags.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        predicted_tags.insert(predicted_tags.size(), frame_byte(in_mon.in_byte));
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_tags.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] output byte %0h with nothing outstanding",
                     $time, out_mon.out_byte);
        end else begin
          want = predicted_tags.pop_front();
          check_field("out_byte",        32'(want.data),    32'(out_mon.out_byte));
          check_field("byte_class",      32'(want.cls),     32'(out_mon.byte_class));
          check_field("request_done",    32'(want.done),    32'(out_mon.request_done));
          check_field("request_aborted", 32'(want.aborted), 32'(out_mon.request_aborted));
          check_field("body_length",     want.blen,         out_mon.body_length);
          if (want.done) requests_done++;
          if (want.aborted) requests_aborted++;
        end
        bytes_checked++;
      end
    end
    outstanding = predicted_tags.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the request framer bench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module testbench import hrf_pkg::*; ;

  // Stop the random part once roughly this many bytes have gone in
  localparam int TARGET_BYTES = 1600;
  // Cycles with no transaction on either channel before we give up
  localparam int IDLE_LIMIT   = 2000;
  // Settling time after the last tagged byte
  localparam int DRAIN_CYCLES = 8;

  // Shapes of a Content-Length value. The first three parse to a usable,
  // small length; the rest fail, or (for the maximum) never finish the body.
  typedef enum int {
    LV_PLAIN,
    LV_PADDED,
    LV_ZERO,
    LV_EMPTY,
    LV_NON_DIGIT,
    LV_INNER_SPACE,
    LV_LEADING_ZERO,
    LV_OVERFLOW,
    LV_MAX
  } length_form_t;

  logic clk;
  logic rst_n;

  hrf_in_if  in_ch();
  hrf_out_if out_ch();

  int  mismatch_total;
  int  tags_pending;
  int  done_count;
  int  abort_count;
  int  tags_checked;
  int  bytes_sent;
  int  quiet_cycles;
  bit  gaps_on;

  // Header names that come close to Content-Length but must not be taken for it
  string near_miss_names [6] = '{"Content-Lengt", "Content-Lengthx", "content-length",
                                 "Content-Length ", "X-Content-Length", "Content_Length"};

  http_request_framer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Watches both channels, predicts every tag and counts disagreements
  hrf_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatches       (mismatch_total),
    .outstanding      (tags_pending),
    .requests_done    (done_count),
    .requests_aborted (abort_count),
    .bytes_checked    (tags_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  // With gaps_on low both sides run flat out.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Mostly lower-case letters, sometimes any byte; the stop bytes are swapped out
  // so that a token cannot end the field it sits in
  function automatic logic [7:0] token_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) b = 8'($urandom_range(0, 255));
    else b = 8'($urandom_range(8'h61, 8'h7A));
    if (b == stop_a || b == stop_b) b = 8'h2E;
    return b;
  endfunction

  // Anything but LF: follows a CR to break the line ending
  function automatic logic [7:0] not_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF) b = 8'h00;
    return b;
  endfunction

  // A byte that spoils a decimal value: not a digit, not a space, not CR
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b >= CH_0 && b <= CH_9) || b == CH_SPACE || b == CH_CR) b = 8'h78;
    return b;
  endfunction

  function automatic int unsigned small_length();
    if ($urandom_range(0, 19) != 0) return $urandom_range(1, 12);
    return $urandom_range(100, 300);
  endfunction

  // One input transaction. Data changes on the falling edge; the transaction
  // completes at the rising edge where ready is seen high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_token(input int lo, input int hi,
                            input logic [7:0] stop_a, input logic [7:0] stop_b);
    repeat ($urandom_range(lo, hi)) send_byte(token_byte(stop_a, stop_b));
  endtask

  // "Content-Length:" and a value of the given shape. finite says whether the
  // body will close after n bytes; a failed or huge value never closes it.
  task automatic send_length_header(input length_form_t form, output bit finite,
                                    output int unsigned n);
    int unsigned v;
    finite = 1'b0;
    n      = 0;
    send_text("Content-Length:");
    case (form)
      LV_PLAIN: begin
        v = small_length();
        send_text($sformatf("%0d", v));
        finite = 1'b1;
        n      = v;
      end
      LV_PADDED: begin
        v = small_length();
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
        send_text($sformatf("%0d", v));
        repeat ($urandom_range(1, 2)) send_byte(CH_SPACE);
        finite = 1'b1;
        n      = v;
      end
      LV_ZERO: begin
        repeat ($urandom_range(0, 1)) send_byte(CH_SPACE);
        send_text("0");
        repeat ($urandom_range(0, 1)) send_byte(CH_SPACE);
        finite = 1'b1;
      end
      LV_EMPTY: repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
      LV_NON_DIGIT: begin
        send_text($sformatf("%0d", small_length()));
        send_byte(junk_byte());
      end
      LV_INNER_SPACE: begin
        send_text($sformatf("%0d", small_length()));
        send_byte(CH_SPACE);
        send_text($sformatf("%0d", $urandom_range(0, 9)));
      end
      LV_LEADING_ZERO: begin
        send_text("0");
        send_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      LV_OVERFLOW: begin
        case ($urandom_range(0, 2))
          0:       send_text("4294967296");
          1:       send_text("99999999999");
          default: send_text("18446744073709551616");
        endcase
      end
      default: send_text("4294967295");
    endcase
  endtask

  // One request with random content. A value that would leave the parser in
  // the body for good is followed by a broken line ending, which throws the
  // request away; only the closing request is left stuck in its body, which
  // then soaks up the rest of the stream.
  task automatic send_request(input bit closing);
    int           n_headers;
    int           kind;
    bit           has_length;
    bit           finite;
    bit           stuck;
    int unsigned  n;
    int unsigned  body_bytes;
    length_form_t form;
    has_length = 1'b0;
    stuck      = 1'b0;
    body_bytes = 0;

    // request line
    send_token(1, 4, CH_SPACE, CH_SPACE);
    send_byte(CH_SPACE);
    if (!closing && $urandom_range(0, 24) == 0) return;
    send_token(0, 6, CH_SPACE, CH_SPACE);
    send_byte(CH_SPACE);
    send_token(0, 5, CH_CR, CH_CR);
    send_byte(CH_CR);
    if (!closing && $urandom_range(0, 24) == 0) begin
      send_byte(not_lf());
      return;
    end
    send_byte(CH_LF);

    // header lines
    n_headers = $urandom_range(0, 3);
    for (int i = 0; i < n_headers; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        if (has_length) begin
          // a second Content-Length spoils the first
          send_length_header(LV_PLAIN, finite, n);
          stuck = 1'b1;
        end else begin
          if ($urandom_range(0, 9) < 7) form = length_form_t'($urandom_range(LV_PLAIN, LV_ZERO));
          else form = length_form_t'($urandom_range(LV_EMPTY, LV_MAX));
          send_length_header(form, finite, n);
          has_length = 1'b1;
          stuck      = !finite;
          body_bytes = n;
        end
      end else if (kind == 3) begin
        send_text(near_miss_names[$urandom_range(0, 5)]);
        send_byte(CH_COLON);
        send_token(0, 6, CH_CR, CH_CR);
      end else begin
        send_token(1, 8, CH_COLON, CH_CR);
        send_byte(CH_COLON);
        send_token(0, 8, CH_CR, CH_CR);
      end
      send_byte(CH_CR);
      if (!closing && (stuck || $urandom_range(0, 29) == 0)) begin
        send_byte(not_lf());
        return;
      end
      send_byte(CH_LF);
    end

    if (closing) begin
      if (has_length) send_length_header(LV_PLAIN, finite, n);
      else send_length_header(length_form_t'($urandom_range(LV_EMPTY, LV_MAX)), finite, n);
      has_length = 1'b1;
      send_byte(CH_CR);
      send_byte(CH_LF);
    end

    // end of headers: a blank line, or now and then a line with no colon
    if ($urandom_range(0, 5) == 0) send_token(1, 6, CH_COLON, CH_CR);
    send_byte(CH_CR);
    if (!closing && $urandom_range(0, 29) == 0) begin
      send_byte(not_lf());
      return;
    end
    send_byte(CH_LF);

    if (closing) body_bytes = $urandom_range(20, 60);
    else if (!has_length) body_bytes = 0;
    repeat (body_bytes) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Output side: runs of ready broken by stalls of the same shape as the input gaps
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (pick_gap() != 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
      end
    end
  end

  // Watchdog: any transaction on either channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d idle cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    gaps_on       = 1'b1;
    bytes_sent    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes in every request-line field, then a blank line
    // that completes the request with no headers
    send_byte(8'h00);
    send_byte(CH_SPACE);
    send_byte(8'hFF);
    send_byte(CH_SPACE);
    send_byte(8'h7F);
    send_text("\r\n\r\n");
    // bad line ending after the request line
    send_text("A B C\r");
    send_byte(CH_CR);
    // empty method and url, then a bad line ending where the blank line should be
    send_text("  \r\n\r");
    send_byte(8'h5A);

    // Random requests, with the odd burst of raw noise between them
    while (bytes_sent < TARGET_BYTES) begin
      gaps_on = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      send_request(1'b0);
    end
    // last request carries a failing or huge length and leaves the parser in its body
    gaps_on = 1'b1;
    send_request(1'b1);
    in_ch.valid <= 1'b0;

    while (tags_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d request bytes, %0d tagged bytes checked", bytes_sent, tags_checked);
    $display("Requests completed: %0d, discarded on bad line endings: %0d",
             done_count, abort_count);
    if (mismatch_total == 0 && tags_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
